### design/fpts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpts_pkg: shared types and constants of the feedback priority task scheduler
// Event codes, table sizing and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package fpts_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned SlotBits   = $clog2(TableDepth);
  localparam int unsigned IdBits     = 16;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned PrioBits   = 3;
  localparam int unsigned PeriodBits = 16;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [PeriodBits-1:0] BoostPeriodRst = PeriodBits'(10);
  localparam logic [PrioBits-1:0]   TopPrioRst     = PrioBits'(7);

  typedef enum logic [1:0] {
    CMD_ARRIVAL = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_IO_REQ  = 2'd2,
    CMD_IO_END  = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_BOOST_PERIOD = 1'b0,
    CFG_TOP_PRIORITY = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [IdBits-1:0]   task_id;
    logic [TimeBits-1:0] arrival_time;
    logic [TimeBits-1:0] deadline;
    logic [TimeBits-1:0] now;
    logic [IdBits-1:0]   running_cpu;
    logic [IdBits-1:0]   running_io;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [IdBits-1:0] cpu_task;
    logic [IdBits-1:0] io_task;
    logic              overflow;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic scan_clr;  // reset scan counter and search state
    logic scan_step; // visit one slot
    logic apply;     // apply event to found slot
    logic div_start; // start modulo unit
    logic div_step;  // one modulo iteration
    logic pick_clr;  // reset best-entry search
    logic finish;    // register result, demote, clear io flag
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic last;
  } dp_sts_t;
endpackage
`default_nettype wire

### design/fpts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpts_stream_if: valid/ready channel
// Carries one payload per transaction between a source and a sink.
// ----------------------------------------------------------------------------
interface fpts_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/fpts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpts_datapath: task table, scan logic, boost modulo unit
// Stores the task table, walks it one slot per cycle for event lookup and
// for best-entry selection, and computes now % boost_period bit-serially.
// ----------------------------------------------------------------------------
module fpts_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire fpts_pkg::dp_cmd_t         cmd_i,
  output fpts_pkg::dp_sts_t              sts_o,
  input  wire fpts_pkg::in_item_t        item_i,
  input  wire [fpts_pkg::PeriodBits-1:0] boost_period_i,
  input  wire [fpts_pkg::PrioBits-1:0]   top_priority_i,
  output fpts_pkg::out_item_t            result_o
);
  localparam int unsigned SB = fpts_pkg::SlotBits;
  localparam int unsigned D  = fpts_pkg::TableDepth;
  localparam int unsigned DW = fpts_pkg::TimeBits + 1;

  fpts_pkg::in_item_t item_q;

  logic [D-1:0] valid_q;
  logic [D-1:0] wait_q;
  logic [fpts_pkg::IdBits-1:0]   task_mem [D];
  logic [fpts_pkg::TimeBits-1:0] slack_mem [D];
  logic [fpts_pkg::PrioBits-1:0] prio_mem [D];
  logic boost_q;  // all priorities read as top until the decision ends

  logic [SB:0] scan_q;
  logic [SB-1:0] slot;
  logic rd_issue;
  assign slot = scan_q[SB-1:0];
  assign rd_issue = cmd_i.scan_step && !scan_q[SB];

  // read stage: table slot data is registered, arriving in the cycle after scan_q addresses the slot
  logic                          rd_ok_q, rd_vld_q, rd_wait_q;
  logic [SB-1:0]                 rd_slot_q;
  logic [fpts_pkg::IdBits-1:0]   rd_task_q;
  logic [fpts_pkg::TimeBits-1:0] rd_slack_q;
  logic [fpts_pkg::PrioBits-1:0] rd_prio_q;

  assign sts_o.scan_done = scan_q[SB] && !rd_ok_q;
  assign sts_o.last = item_q.last;

  // event search state
  logic          free_found_q, id_found_q;
  logic [SB-1:0] free_slot_q, id_slot_q;
  logic          io_ended_q, overflow_q;

  // best-entry search state
  logic                          cb_found_q, ib_found_q;
  logic [SB-1:0]                 cb_slot_q;
  logic [fpts_pkg::PrioBits-1:0] cb_prio_q, ib_prio_q;
  logic [fpts_pkg::TimeBits-1:0] cb_slack_q, ib_slack_q;
  logic [fpts_pkg::IdBits-1:0]   cb_task_q, ib_task_q;

  logic [fpts_pkg::PrioBits-1:0] cur_prio;
  assign cur_prio = boost_q ? top_priority_i : rd_prio_q;

  // restoring modulo: one quotient bit per step
  logic [5:0]  div_cnt_q;
  logic [fpts_pkg::TimeBits-1:0] div_rem_q, div_num_q;
  logic [DW-1:0]                 div_trial, div_den;
  assign div_trial = {div_rem_q, div_num_q[fpts_pkg::TimeBits-1]};
  assign div_den = DW'(boost_period_i);
  assign sts_o.div_done = (div_cnt_q == 6'd0);

  logic cand_ok;
  logic better_c, better_i;
  assign cand_ok = rd_vld_q;
  assign better_c = !cb_found_q || (cur_prio > cb_prio_q) ||
                    (cur_prio == cb_prio_q && rd_slack_q < cb_slack_q);
  assign better_i = !ib_found_q || (cur_prio > ib_prio_q) ||
                    (cur_prio == ib_prio_q && rd_slack_q < ib_slack_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (rd_issue) begin
      rd_task_q  <= task_mem[slot];
      rd_slack_q <= slack_mem[slot];
      rd_prio_q  <= prio_mem[slot];
    end
    if (cmd_i.apply && item_q.cmd == fpts_pkg::CMD_ARRIVAL && free_found_q) begin
      task_mem[free_slot_q]  <= item_q.task_id;
      slack_mem[free_slot_q] <= (item_q.deadline >= item_q.arrival_time) ?
                                item_q.deadline - item_q.arrival_time : '0;
      prio_mem[free_slot_q]  <= top_priority_i;
    end else if (boost_q && rd_ok_q) begin
      // boost is written back slot by slot during the selection scan
      prio_mem[rd_slot_q] <= top_priority_i;
    end else if (cmd_i.finish && cb_found_q && cb_prio_q != '0) begin
      prio_mem[cb_slot_q] <= cb_prio_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      wait_q <= '0;
      scan_q <= '0;
      rd_ok_q <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_wait_q <= 1'b0;
      rd_slot_q <= '0;
      free_found_q <= 1'b0;
      id_found_q <= 1'b0;
      free_slot_q <= '0;
      id_slot_q <= '0;
      io_ended_q <= 1'b0;
      overflow_q <= 1'b0;
      boost_q <= 1'b0;
      cb_found_q <= 1'b0;
      ib_found_q <= 1'b0;
      cb_slot_q <= '0;
      cb_prio_q <= '0;
      ib_prio_q <= '0;
      cb_slack_q <= '0;
      ib_slack_q <= '0;
      cb_task_q <= '0;
      ib_task_q <= '0;
      div_cnt_q <= '0;
      div_rem_q <= '0;
      div_num_q <= '0;
      result_o <= '0;
    end else begin
      if (cmd_i.scan_clr || cmd_i.pick_clr) begin
        scan_q <= '0;
        rd_ok_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_ok_q <= !scan_q[SB];
        if (!scan_q[SB]) begin
          scan_q <= scan_q + 1'b1;
          rd_vld_q <= valid_q[slot];
          rd_wait_q <= wait_q[slot];
          rd_slot_q <= slot;
        end
      end
      if (cmd_i.scan_clr) begin
        free_found_q <= 1'b0;
        id_found_q <= 1'b0;
      end
      if (cmd_i.pick_clr) begin
        cb_found_q <= 1'b0;
        ib_found_q <= 1'b0;
        cb_task_q <= '0;
        ib_task_q <= '0;
      end
      if (rd_ok_q) begin
        if (!rd_vld_q && !free_found_q) begin
          free_found_q <= 1'b1;
          free_slot_q <= rd_slot_q;
        end
        if (rd_vld_q && rd_task_q == item_q.task_id && !id_found_q) begin
          id_found_q <= 1'b1;
          id_slot_q <= rd_slot_q;
        end
        if (cand_ok && !rd_wait_q && better_c) begin
          cb_found_q <= 1'b1;
          cb_slot_q <= rd_slot_q;
          cb_prio_q <= cur_prio;
          cb_slack_q <= rd_slack_q;
          cb_task_q <= rd_task_q;
        end
        if (cand_ok && rd_wait_q && better_i) begin
          ib_found_q <= 1'b1;
          ib_prio_q <= cur_prio;
          ib_slack_q <= rd_slack_q;
          ib_task_q <= rd_task_q;
        end
      end
      if (cmd_i.apply) begin
        if (item_q.cmd == fpts_pkg::CMD_ARRIVAL) begin
          if (free_found_q) begin
            valid_q[free_slot_q] <= 1'b1;
            wait_q[free_slot_q] <= 1'b0;
          end else begin
            overflow_q <= 1'b1;
          end
        end else begin
          if (item_q.cmd == fpts_pkg::CMD_IO_END && item_q.task_id == item_q.running_io)
            io_ended_q <= 1'b1;
          if (id_found_q) begin
            if (item_q.cmd == fpts_pkg::CMD_FINISH) valid_q[id_slot_q] <= 1'b0;
            else wait_q[id_slot_q] <= (item_q.cmd == fpts_pkg::CMD_IO_REQ);
          end
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= 6'(fpts_pkg::TimeBits);
        div_rem_q <= '0;
        div_num_q <= item_q.now;
      end
      if (cmd_i.div_step && div_cnt_q != 6'd0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        div_num_q <= div_num_q << 1;
        if (div_trial >= div_den) begin
          div_rem_q <= fpts_pkg::TimeBits'(div_trial - div_den);
        end else begin
          div_rem_q <= div_trial[fpts_pkg::TimeBits-1:0];
        end
        if (div_cnt_q == 6'd1)
          boost_q <= (boost_period_i != '0) &&
                     (((div_trial >= div_den) ?
                       fpts_pkg::TimeBits'(div_trial - div_den) :
                       div_trial[fpts_pkg::TimeBits-1:0]) == '0);
      end
      if (cmd_i.finish) begin
        boost_q <= 1'b0;
        io_ended_q <= 1'b0;
        result_o.cpu_task <= cb_task_q;
        result_o.io_task <= (item_q.running_io != '0 && !io_ended_q) ?
                            item_q.running_io : ib_task_q;
        result_o.overflow <= overflow_q;
      end
    end
  end
endmodule
`default_nettype wire

### design/fpts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpts_ctrl: scheduler sequencer
// Steps through event lookup, event update and, for the last item of a batch,
// boost check, selection scan and result hand-off, one input transaction at a time.
// ----------------------------------------------------------------------------
module fpts_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  wire fpts_pkg::dp_sts_t sts_i,
  output fpts_pkg::dp_cmd_t      cmd_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLook = 3'd1;
  localparam logic [2:0] StApply = 3'd2;
  localparam logic [2:0] StDiv = 3'd3;
  localparam logic [2:0] StPick = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic fire;

  // the result register decouples the sides; a decision waits in StDone
  // until the previous result has been handed off
  assign in_ready_o = (state_q == StIdle);
  assign fire = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (fire) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = StLook;
        end
      end
      StLook: begin
        if (sts_i.scan_done) state_d = StApply;
        else cmd_o.scan_step = 1'b1;
      end
      StApply: begin
        cmd_o.apply = 1'b1;
        if (sts_i.last) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.div_step = 1'b0;
          cmd_o.pick_clr = 1'b1;
          state_d = StPick;
        end
      end
      StPick: begin
        if (sts_i.scan_done) state_d = StDone;
        else cmd_o.scan_step = 1'b1;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

### design/feedback_priority_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_priority_task_scheduler: multilevel feedback task scheduler
// Keeps a 64-entry task table and picks CPU and I/O tasks per batch.
// ----------------------------------------------------------------------------
// One transaction at a time. An event with last = 0 runs a lookup scan
// of the 64-entry table at one slot per cycle with a registered read, an
// update step and the idle state that takes the next item. An event with
// last = 1 runs the lookup scan, the update step, a 32-step serial modulo
// for the boost check plus a hand-over step, a second selection scan and a
// result step that registers the result. The result sits in an output
// register, so the next item is accepted while it waits; a later decision
// holds in its result state until the earlier result has been taken.
module feedback_priority_task_scheduler (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  fpts_stream_if.sink                         in_if,
  fpts_stream_if.source                       out_if,
  input  wire                                 cfg_we_i,
  input  wire                                 cfg_idx_i,
  input  wire [fpts_pkg::CfgDataBits-1:0]     cfg_data_i
);
  logic [fpts_pkg::PeriodBits-1:0] boost_period_q;
  logic [fpts_pkg::PrioBits-1:0]   top_priority_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boost_period_q <= fpts_pkg::BoostPeriodRst;
      top_priority_q <= fpts_pkg::TopPrioRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpts_pkg::CFG_BOOST_PERIOD: boost_period_q <= cfg_data_i;
        fpts_pkg::CFG_TOP_PRIORITY: top_priority_q <= cfg_data_i[fpts_pkg::PrioBits-1:0];
        default: ;
      endcase
    end
  end

  fpts_pkg::dp_cmd_t cmd;
  fpts_pkg::dp_sts_t sts;

  fpts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fpts_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .item_i         (in_if.data),
    .boost_period_i (boost_period_q),
    .top_priority_i (top_priority_q),
    .result_o       (out_if.data)
  );

  // a decision result appears only after a finish command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(cmd.finish))
    else $error("result without decision");
  // a pending result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("pending result changed");
  // overflow flag is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_if.data.overflow) && $past(out_if.valid) |-> out_if.data.overflow)
    else $error("overflow flag cleared");
endmodule
`default_nettype wire
